// ===== rtl/circular_list_engine_defines.svh =====
// Assertion macros shared by the checker of the circular list engine.
// Depends on nothing; included by the files that hold assertions.
`ifndef CIRCULAR_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_LIST_ENGINE_DEFINES_SVH

// Property that must hold in the same cycle as its condition.
`define CLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its condition.
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cle_pkg.sv =====
// Shared types and constants of the circular list engine.
// Depends on nothing; used by every other file of the block but the defines header.
package cle_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_READ    = 3'd3,
    CMD_REVERSE = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fs_ctrl_t;

  typedef struct packed {
    logic link_we;
    logic val_we;
  } nm_wr_t;

endpackage

// ===== rtl/cle_if.sv =====
// Valid/ready channel interfaces for commands and results of the list engine.
// Depends on cle_pkg for the field widths.
interface cle_in_if import cle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] item_value;

  modport source (output valid, output cmd, output position, output item_value, input ready);
  modport sink (input valid, input cmd, input position, input item_value, output ready);
endinterface

interface cle_out_if import cle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_value;
  logic [LEN_W-1:0]    length;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output read_value, output length, output status, input ready);
  modport sink (input valid, input read_value, input length, input status, output ready);
endinterface

// ===== rtl/circular_list_engine.sv =====
// Circular singly linked list engine: command sequencer over the node pool and free stack.
// Depends on cle_pkg, cle_if, cle_node_mem and cle_free_stack.
//
// One command is taken at a time and answered with exactly one result. The sequencer
// follows one link per cycle through the link memory, so the link memory read port sets
// the time per command: a read walks to position p, insert and delete at position p > 0
// walk to the node before p, insert and delete at the head and append walk no links,
// reverse visits every entry, and out-of-range, full, short reverse and unknown commands
// go straight to their result. The next command can be taken in the cycle after the
// result is loaded. A finished result waits in the output register while the next
// command is taken. After reset the free stack is filled with every node index, during
// which no command is taken.
module circular_list_engine import cle_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  cle_in_if.sink           in_ch,
  cle_out_if.source        out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_WALK, S_DEL0, S_DEL1, S_LINK2, S_REV, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]      first_r, first_nxt;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [IDX_W-1:0]      prev_r, prev_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [IDX_W-1:0]      wa2_r, wa2_nxt;
  logic [IDX_W-1:0]      wd2_r, wd2_nxt;
  logic [DATA_W-1:0]     res_value_r, res_value_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_value_r, out_value_nxt;
  logic [LEN_W-1:0]      out_length_r, out_length_nxt;
  status_t               out_status_r, out_status_nxt;

  logic [IDX_W-1:0]       rd_addr;
  nm_wr_t                 wr;
  logic [IDX_W-1:0]       link_wa;
  logic [IDX_W-1:0]       link_wd;
  logic [IDX_W-1:0]       val_wa;
  logic [VALUE_WIDTH-1:0] val_wd;
  logic [IDX_W-1:0]       link_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  fs_ctrl_t               fs_ctl;
  logic [IDX_W-1:0]       push_idx;
  logic [IDX_W-1:0]       fs_rd;
  logic                   fs_empty;
  logic                   fs_busy;
  logic                   in_ready;
  logic                   in_range;
  logic                   pos_zero;
  logic [CNT_W-1:0]       pos_cnt;

  cle_node_mem #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_node_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .link_wa (link_wa),
    .link_wd (link_wd),
    .val_wa  (val_wa),
    .val_wd  (val_wd),
    .link_rd (link_rd),
    .val_rd  (val_rd)
  );

  cle_free_stack #(
    .CAPACITY (CAPACITY)
  ) u_free_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fs_ctl),
    .push_idx (push_idx),
    .top_idx  (fs_rd),
    .empty    (fs_empty),
    .busy     (fs_busy)
  );

  assign in_ready = (state_r == S_IDLE) && !fs_busy;
  assign in_range = CMP_W'(in_ch.position) < CMP_W'(count_r);
  assign pos_zero = (in_ch.position == '0);
  assign pos_cnt  = CNT_W'(in_ch.position);

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.length     = out_length_r;
  assign out_ch.status     = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    rem_nxt        = rem_r;
    wa2_nxt        = wa2_r;
    wd2_nxt        = wd2_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_length_nxt = out_length_r;
    out_status_nxt = out_status_r;
    rd_addr        = cur_r;
    wr             = '0;
    link_wa        = cur_r;
    link_wd        = prev_r;
    val_wa         = fs_rd;
    val_wd         = val_r;
    fs_ctl         = '0;
    push_idx       = cur_r;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = first_r;
        if (in_ch.valid && in_ready) begin
          cmd_nxt        = cmd_t'(in_ch.cmd);
          val_nxt        = VALUE_WIDTH'(in_ch.item_value);
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          cur_nxt        = first_r;
          prev_nxt       = last_r;
          state_nxt      = S_DONE;
          unique case (cmd_t'(in_ch.cmd))
            CMD_APPEND: begin
              if (fs_empty) begin
                res_status_nxt = ST_FULL;
              end else begin
                state_nxt = S_POP;
              end
            end
            CMD_INSERT: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else if (fs_empty) begin
                res_status_nxt = ST_FULL;
              end else if (pos_zero) begin
                state_nxt = S_POP;
              end else begin
                rem_nxt   = pos_cnt - CNT_W'(1);
                state_nxt = S_WALK;
              end
            end
            CMD_DELETE: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else if (pos_zero) begin
                state_nxt = S_DEL0;
              end else begin
                rem_nxt   = pos_cnt - CNT_W'(1);
                state_nxt = S_WALK;
              end
            end
            CMD_READ: begin
              if (!in_range) begin
                res_status_nxt = ST_RANGE;
              end else begin
                rem_nxt   = pos_cnt;
                state_nxt = S_WALK;
              end
            end
            CMD_REVERSE: begin
              if (count_r >= CNT_W'(2)) begin
                rem_nxt   = count_r - CNT_W'(1);
                state_nxt = S_REV;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        fs_ctl.pop  = 1'b1;
        wr.val_we   = 1'b1;
        wr.link_we  = 1'b1;
        count_nxt   = count_r + CNT_W'(1);
        if (cmd_r == CMD_APPEND) begin
          if (count_r == '0) begin
            link_wa   = fs_rd;
            link_wd   = fs_rd;
            first_nxt = fs_rd;
            last_nxt  = fs_rd;
            state_nxt = S_DONE;
          end else begin
            link_wa   = last_r;
            link_wd   = fs_rd;
            wa2_nxt   = fs_rd;
            wd2_nxt   = first_r;
            last_nxt  = fs_rd;
            state_nxt = S_LINK2;
          end
        end else begin
          link_wa   = fs_rd;
          link_wd   = first_r;
          wa2_nxt   = last_r;
          wd2_nxt   = fs_rd;
          first_nxt = fs_rd;
          state_nxt = S_LINK2;
        end
      end

      S_LINK2: begin
        wr.link_we = 1'b1;
        link_wa    = wa2_r;
        link_wd    = wd2_r;
        state_nxt  = S_DONE;
      end

      S_WALK: begin
        rd_addr = link_rd;
        if (rem_r != '0) begin
          cur_nxt = link_rd;
          rem_nxt = rem_r - CNT_W'(1);
        end else begin
          unique case (cmd_r)
            CMD_INSERT: begin
              fs_ctl.pop = 1'b1;
              wr.val_we  = 1'b1;
              wr.link_we = 1'b1;
              link_wa    = fs_rd;
              link_wd    = link_rd;
              wa2_nxt    = cur_r;
              wd2_nxt    = fs_rd;
              count_nxt  = count_r + CNT_W'(1);
              state_nxt  = S_LINK2;
            end
            CMD_DELETE: begin
              prev_nxt  = cur_r;
              cur_nxt   = link_rd;
              state_nxt = S_DEL1;
            end
            default: begin
              res_value_nxt = DATA_W'(val_rd);
              state_nxt     = S_DONE;
            end
          endcase
        end
      end

      S_DEL0: begin
        fs_ctl.push = 1'b1;
        push_idx    = cur_r;
        count_nxt   = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          first_nxt = '0;
          last_nxt  = '0;
        end else begin
          wr.link_we = 1'b1;
          link_wa    = last_r;
          link_wd    = link_rd;
          first_nxt  = link_rd;
        end
        state_nxt = S_DONE;
      end

      S_DEL1: begin
        wr.link_we  = 1'b1;
        link_wa     = prev_r;
        link_wd     = link_rd;
        fs_ctl.push = 1'b1;
        push_idx    = cur_r;
        count_nxt   = count_r - CNT_W'(1);
        if (cur_r == last_r) begin
          last_nxt = prev_r;
        end
        state_nxt = S_DONE;
      end

      S_REV: begin
        rd_addr    = link_rd;
        wr.link_we = 1'b1;
        link_wa    = cur_r;
        link_wd    = prev_r;
        prev_nxt   = cur_r;
        cur_nxt    = link_rd;
        if (rem_r == '0) begin
          first_nxt = last_r;
          last_nxt  = first_r;
          state_nxt = S_DONE;
        end else begin
          rem_nxt = rem_r - CNT_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_length_nxt = LEN_W'(count_r);
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      last_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    rem_r        <= rem_nxt;
    wa2_r        <= wa2_nxt;
    wd2_r        <= wd2_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_length_r <= out_length_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== rtl/cle_node_mem.sv =====
// Node pool of the list engine: value memory and link memory on one read address.
// Depends on cle_pkg for the write control struct.
module cle_node_mem import cle_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
  input  nm_wr_t                        wr,
  input  logic [$clog2(CAPACITY)-1:0]   link_wa,
  input  logic [$clog2(CAPACITY)-1:0]   link_wd,
  input  logic [$clog2(CAPACITY)-1:0]   val_wa,
  input  logic [VALUE_WIDTH-1:0]        val_wd,
  output logic [$clog2(CAPACITY)-1:0]   link_rd,
  output logic [VALUE_WIDTH-1:0]        val_rd
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic [IDX_W-1:0]       link_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_rd <= val_mem[rd_addr];
  end

endmodule

// ===== rtl/cle_free_stack.sv =====
// Free node stack of the list engine, filled with every node index after reset.
// Depends on cle_pkg for the push and pop control struct.
module cle_free_stack import cle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fs_ctrl_t                      ctl,
  input  logic [$clog2(CAPACITY)-1:0]   push_idx,
  output logic [$clog2(CAPACITY)-1:0]   top_idx,
  output logic                          empty,
  output logic                          busy
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [IDX_W-1:0] stack_mem [CAPACITY];
  logic [CNT_W-1:0] top_r;
  logic [IDX_W-1:0] clr_r;
  logic             busy_r;
  logic [IDX_W-1:0] rd_addr;
  logic             push_ok;

  assign rd_addr = IDX_W'(top_r - CNT_W'(1));
  assign push_ok = ctl.push && (top_r < CNT_W'(CAPACITY));
  assign empty   = (top_r == '0);
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
      top_r  <= CNT_W'(CAPACITY);
    end else if (busy_r) begin
      clr_r <= clr_r + IDX_W'(1);
      if (clr_r == IDX_W'(CAPACITY - 1)) begin
        busy_r <= 1'b0;
      end
    end else if (ctl.pop) begin
      top_r <= top_r - CNT_W'(1);
    end else if (push_ok) begin
      top_r <= top_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      stack_mem[clr_r] <= clr_r;
    end else if (push_ok) begin
      stack_mem[top_r[IDX_W-1:0]] <= push_idx;
    end
    top_idx <= stack_mem[rd_addr];
  end

endmodule

// ===== rtl/cle_checker.sv =====
// Port-level checker for the circular list engine, bound to the top level.
// Depends on cle_pkg and circular_list_engine_defines.svh.
`include "circular_list_engine_defines.svh"

module cle_checker import cle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DATA_W-1:0]   out_read_value,
  input logic [LEN_W-1:0]    out_length,
  input logic [STATUS_W-1:0] out_status
);

  `CLE_ASSERT_SAME(a_err_value_zero, clk, rst_n, out_valid && (out_status != ST_OK), out_read_value == '0, "A failed command returned a nonzero value.")
  `CLE_ASSERT_SAME(a_full_length, clk, rst_n, out_valid && (out_status == ST_FULL), out_length == LEN_W'(CAPACITY), "Pool full reported while the list is not at capacity.")
  `CLE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "A command was taken while another was still in progress.")
  `CLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_length), "A stalled result changed before its transfer.")

endmodule

bind circular_list_engine cle_checker #(
  .CAPACITY (CAPACITY)
) u_cle_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_length     (out_ch.length),
  .out_status     (out_ch.status)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for the circular list engine: a directed table, a pool fill, then
// random commands, checked against a queue model of the list with random flow control.
// Depends on cle_pkg, the cle_in_if/cle_out_if interfaces and circular_list_engine.
module tb_top;
  import cle_pkg::*;

  localparam int POOL_SIZE = 64;
  localparam int TOTAL_ITEMS = 1050;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0]   read_value;
    logic [LEN_W-1:0]    length;
    logic [STATUS_W-1:0] status;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic              typed;
    reply_t            want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  cle_in_if  in_if ();
  cle_out_if out_if ();

  circular_list_engine #(
    .CAPACITY    (POOL_SIZE),
    .VALUE_WIDTH (DATA_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic [DATA_W-1:0] list_contents[$];
  reply_t pending_replies[$];
  stim_row_t directed_rows[$];
  int items_sent = 0;
  int replies_seen = 0;
  int mismatch_count = 0;
  int burst_left = 1;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic reply_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                            input logic [POS_W-1:0] p,
                                            input logic [DATA_W-1:0] v);
    reply_t r;
    logic [DATA_W-1:0] flipped[$];
    int n;
    n = list_contents.size();
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_APPEND: begin
        if (n == POOL_SIZE) r.status = ST_FULL;
        else list_contents.push_back(v);
      end
      CMD_INSERT: begin
        if (p >= n) r.status = ST_RANGE;
        else if (n == POOL_SIZE) r.status = ST_FULL;
        else list_contents.insert(p, v);
      end
      CMD_DELETE: begin
        if (p >= n) r.status = ST_RANGE;
        else list_contents.delete(p);
      end
      CMD_READ: begin
        if (p >= n) r.status = ST_RANGE;
        else r.read_value = list_contents[p];
      end
      CMD_REVERSE: begin
        for (int i = 0; i < n; i++) flipped.push_front(list_contents[i]);
        list_contents = flipped;
      end
      default: ;
    endcase
    r.length = LEN_W'(list_contents.size());
    return r;
  endfunction

  function automatic stim_row_t row(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                                    input logic [DATA_W-1:0] v, input logic typed,
                                    input logic [DATA_W-1:0] rd, input int len,
                                    input status_t st);
    stim_row_t s;
    s.cmd = c;
    s.pos = p;
    s.value = v;
    s.typed = typed;
    s.want.read_value = rd;
    s.want.length = LEN_W'(len);
    s.want.status = st;
    return s;
  endfunction

  // Offers one command; returns at its transfer with valid high, or at a burst's end
  // after a gap, valid low. The table's expected reply is used where one is typed in.
  task automatic issue(input stim_row_t s);
    reply_t predicted;
    int gap;
    in_if.valid <= 1'b1;
    in_if.cmd <= s.cmd;
    in_if.position <= s.pos;
    in_if.item_value <= s.value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = apply_list_cmd(s.cmd, s.pos, s.value);
    pending_replies.push_back(s.typed ? s.want : predicted);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      in_if.cmd <= CMD_W'($urandom());
      in_if.position <= POS_W'($urandom());
      in_if.item_value <= $urandom();
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
  endtask

  initial begin
    int mode;
    int episode_left;
    int cuts[5];
    int r;
    int n;
    logic [CMD_W-1:0] c;
    logic [POS_W-1:0] p;

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd <= '0;
    in_if.position <= '0;
    in_if.item_value <= '0;

    directed_rows.push_back(row(CMD_READ, 0, 32'h0, 1, 32'h0, 0, ST_RANGE));
    directed_rows.push_back(row(CMD_INSERT, 0, 32'hAAAA_AAAA, 1, 32'h0, 0, ST_RANGE));
    directed_rows.push_back(row(CMD_DELETE, 0, 32'h0, 1, 32'h0, 0, ST_RANGE));
    directed_rows.push_back(row(CMD_REVERSE, 0, 32'h0, 1, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_SPARE_FIRST, 63, 32'h5555_5555, 1, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_APPEND, 0, 32'hFFFF_FFFF, 1, 32'h0, 1, ST_OK));
    directed_rows.push_back(row(CMD_REVERSE, 0, 32'h0, 1, 32'h0, 1, ST_OK));
    directed_rows.push_back(row(CMD_READ, 0, 32'h0, 1, 32'hFFFF_FFFF, 1, ST_OK));
    directed_rows.push_back(row(CMD_INSERT, 1, 32'h1, 1, 32'h0, 1, ST_RANGE));
    directed_rows.push_back(row(CMD_INSERT, 0, 32'h0, 1, 32'h0, 2, ST_OK));
    directed_rows.push_back(row(CMD_READ, 0, 32'h0, 1, 32'h0, 2, ST_OK));
    directed_rows.push_back(row(CMD_READ, 1, 32'h0, 1, 32'hFFFF_FFFF, 2, ST_OK));
    directed_rows.push_back(row(CMD_REVERSE, 0, 32'h0, 1, 32'h0, 2, ST_OK));
    directed_rows.push_back(row(CMD_READ, 0, 32'h0, 1, 32'hFFFF_FFFF, 2, ST_OK));
    directed_rows.push_back(row(CMD_READ, 63, 32'h0, 1, 32'h0, 2, ST_RANGE));
    directed_rows.push_back(row(CMD_APPEND, 0, 32'h1234_5678, 1, 32'h0, 3, ST_OK));
    directed_rows.push_back(row(CMD_INSERT, 2, 32'h5A5A_5A5A, 0, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_READ, 2, 32'h0, 0, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_DELETE, 3, 32'h0, 0, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_APPEND, 0, 32'h0F0F_0F0F, 0, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_REVERSE, 0, 32'h0, 0, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_READ, 3, 32'h0, 0, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_DELETE, 0, 32'h0, 0, 32'h0, 0, ST_OK));
    directed_rows.push_back(row(CMD_SPARE_LAST, 0, 32'h0, 0, 32'h0, 0, ST_OK));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) issue(directed_rows[i]);

    // Fill the pool completely, then exercise the full case and the longest walks.
    while (list_contents.size() < POOL_SIZE)
      issue(row(CMD_APPEND, POS_W'($urandom()), $urandom(), 0, 32'h0, 0, ST_OK));
    issue(row(CMD_APPEND, 0, $urandom(), 0, 32'h0, 0, ST_OK));
    issue(row(CMD_INSERT, 0, $urandom(), 0, 32'h0, 0, ST_OK));
    issue(row(CMD_INSERT, 63, $urandom(), 0, 32'h0, 0, ST_OK));
    issue(row(CMD_REVERSE, 0, 32'h0, 0, 32'h0, 0, ST_OK));
    issue(row(CMD_READ, 63, 32'h0, 0, 32'h0, 0, ST_OK));
    issue(row(CMD_DELETE, 63, 32'h0, 0, 32'h0, 0, ST_OK));
    issue(row(CMD_INSERT, 62, $urandom(), 0, 32'h0, 0, ST_OK));

    // Random episodes that grow, shrink or churn the list with random content.
    episode_left = 0;
    mode = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (episode_left == 0) begin
        mode = $urandom_range(0, 2);
        episode_left = $urandom_range(20, 80);
        case (mode)
          0: cuts = '{40, 70, 78, 92, 97};
          1: cuts = '{10, 20, 65, 88, 95};
          default: cuts = '{25, 45, 70, 88, 96};
        endcase
      end
      episode_left--;
      r = $urandom_range(0, 99);
      if (r < cuts[0]) c = CMD_APPEND;
      else if (r < cuts[1]) c = CMD_INSERT;
      else if (r < cuts[2]) c = CMD_DELETE;
      else if (r < cuts[3]) c = CMD_READ;
      else if (r < cuts[4]) c = CMD_REVERSE;
      else c = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      n = list_contents.size();
      if (n > 0 && $urandom_range(0, 99) < 85) p = POS_W'($urandom_range(0, n - 1));
      else p = POS_W'($urandom_range(0, 63));
      issue(row(c, p, $urandom(), 0, 32'h0, 0, ST_OK));
    end

    in_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The receiver stalls on a pattern that changes every so often, and once holds off
  // for a long stretch so that the engine backs up onto its input.
  initial begin
    int stall_mode;
    int mode_left;
    int phase_count;
    bit held_off;
    out_if.ready <= 1'b0;
    stall_mode = 0;
    mode_left = 0;
    phase_count = 0;
    held_off = 0;
    forever begin
      @(posedge clk);
      if (!held_off && replies_seen >= 300) begin
        held_off = 1;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        phase_count++;
        case (stall_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 99) < 70);
          2: out_if.ready <= (phase_count % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 99) < 30);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected transfer rd=%h len=%0d st=%0d", $time,
                   out_if.read_value, out_if.length, out_if.status);
      end else begin
        want = pending_replies.pop_front();
        if (out_if.read_value !== want.read_value || out_if.length !== want.length ||
            out_if.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch, expected rd=%h len=%0d st=%0d, got rd=%h len=%0d st=%0d",
                     $time, want.read_value, want.length, want.status,
                     out_if.read_value, out_if.length, out_if.status);
        end
      end
    end
  end

endmodule
